### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers included by the checker file hrp_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### sv/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, codes and character tables of the HTTP request header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrp_pkg;

  localparam int RESOURCE_LEN_DEF = 100;
  localparam int METHOD_LEN_DEF   = 10;
  localparam int NAME_LEN_DEF     = 20;
  localparam int VALUE_LEN_DEF    = 10;

  localparam int LEN_W   = 30;
  localparam int BYTES_W = 18;

  localparam logic [LEN_W-1:0]   LEN_CAP       = 30'd999999999;
  localparam logic [BYTES_W-1:0] MAX_BYTES_RST = 18'd249999;
  localparam int                 CL_WORD_LEN   = 14;

  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_SP    = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_VT    = 8'h0b;
  localparam logic [7:0] CHR_FF    = 8'h0c;
  localparam logic [7:0] CHR_COLON = 8'h3a;
  localparam logic [7:0] CHR_PLUS  = 8'h2b;
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_9     = 8'h39;

  localparam logic [2:0] CLS_METHOD   = 3'd0;
  localparam logic [2:0] CLS_RESOURCE = 3'd1;
  localparam logic [2:0] CLS_REST     = 3'd2;
  localparam logic [2:0] CLS_NAME     = 3'd3;
  localparam logic [2:0] CLS_VALUE    = 3'd4;
  localparam logic [2:0] CLS_BODY     = 3'd5;
  localparam logic [2:0] CLS_DROP     = 3'd6;

  localparam logic [1:0] MTH_NONE = 2'd0;
  localparam logic [1:0] MTH_GET  = 2'd1;
  localparam logic [1:0] MTH_HEAD = 2'd2;
  localparam logic [1:0] MTH_POST = 2'd3;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_METHOD = 2'd1;
  localparam logic [1:0] ERR_SIZE   = 2'd2;

  typedef enum logic [2:0] {
    PH_METHOD, PH_RESOURCE, PH_REST, PH_NAME, PH_VALUE, PH_BODY, PH_DONE, PH_ABORT
  } phase_t;

  typedef enum logic [1:0] {
    NS_SKIP, NS_SIGN, NS_DIGITS, NS_STOP
  } num_stage_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       new_request;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [2:0]       byte_class;
    logic             stored;
    logic             headers_done;
    logic             request_done;
    logic [1:0]       method_code;
    logic [LEN_W-1:0] content_length;
    logic [1:0]       error_code;
  } out_item_t;

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] head_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h48;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h41;
      default: c = 8'h44;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] post_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h50;
      2'd1:    c = 8'h4f;
      2'd2:    c = 8'h53;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

  // "Content-Length"
  function automatic logic [7:0] cl_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6e;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2d;
      4'd8:    c = 8'h4c;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### sv/http_request_header_parser.sv
// ----------------------------------------------------------------------------
// http_request_header_parser
// Input reg and result reg, with the single-pass parser update between the two.
// Throughput: one byte per cycle while the result is not held by out_stall.
// Reset (rst_n low, synchronous): both stages empty, parser at request start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_request_header_parser #(
  parameter int RESOURCE_LEN = hrp_pkg::RESOURCE_LEN_DEF,
  parameter int METHOD_LEN   = hrp_pkg::METHOD_LEN_DEF,
  parameter int NAME_LEN     = hrp_pkg::NAME_LEN_DEF,
  parameter int VALUE_LEN    = hrp_pkg::VALUE_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  hrp_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output hrp_pkg::out_item_t           out_data,
  input  logic                         cfg_wr_en,
  input  logic [hrp_pkg::BYTES_W-1:0]  cfg_wr_data
);

  logic                        in_valid_r;
  hrp_pkg::in_item_t           in_item_r;
  logic                        out_valid_r;
  hrp_pkg::out_item_t          out_item_r;
  logic [hrp_pkg::BYTES_W-1:0] max_bytes_r;
  hrp_pkg::out_item_t          result;
  logic                        advance, in_accept;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  hrp_parser #(
    .RESOURCE_LEN (RESOURCE_LEN),
    .METHOD_LEN   (METHOD_LEN),
    .NAME_LEN     (NAME_LEN),
    .VALUE_LEN    (VALUE_LEN)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .max_bytes (max_bytes_r),
    .item      (in_item_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_bytes_r <= hrp_pkg::MAX_BYTES_RST;
    end else begin
      if (in_accept)    in_valid_r <= 1'b1;
      else if (advance) in_valid_r <= 1'b0;
      if (advance)         out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_wr_en) max_bytes_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) in_item_r <= in_data;
    if (advance)   out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

### sv/hrp_parser.sv
// ----------------------------------------------------------------------------
// hrp_parser
// Parser state and the single-pass per-byte update producing one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrp_parser #(
  parameter int RESOURCE_LEN = hrp_pkg::RESOURCE_LEN_DEF,
  parameter int METHOD_LEN   = hrp_pkg::METHOD_LEN_DEF,
  parameter int NAME_LEN     = hrp_pkg::NAME_LEN_DEF,
  parameter int VALUE_LEN    = hrp_pkg::VALUE_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [hrp_pkg::BYTES_W-1:0]  max_bytes,
  input  hrp_pkg::in_item_t            item,
  output hrp_pkg::out_item_t           result
);

  localparam int TOK_W  = $clog2(RESOURCE_LEN > METHOD_LEN ? RESOURCE_LEN : METHOD_LEN);
  localparam int NAME_W = $clog2(NAME_LEN);
  localparam int VAL_W  = $clog2(VALUE_LEN);
  localparam int LW     = hrp_pkg::LEN_W;
  localparam int BW     = hrp_pkg::BYTES_W;

  hrp_pkg::phase_t     phase_r,  phase_nxt,  c_phase, p;
  logic [TOK_W-1:0]    tok_r,    tok_nxt,    c_tok;
  logic [2:0]          mflags_r, mflags_nxt, c_mflags;
  logic [NAME_W-1:0]   name_r,   name_nxt,   c_name;
  logic                nmatch_r, nmatch_nxt, c_nmatch;
  logic [VAL_W-1:0]    val_r,    val_nxt,    c_val;
  hrp_pkg::num_stage_t nstage_r, nstage_nxt, c_nstage;
  logic                neg_r,    neg_nxt,    c_neg;
  logic                seen_r,   seen_nxt,   c_seen;
  logic [LW-1:0]       nval_r,   nval_nxt,   c_nval;
  logic [LW-1:0]       len_r,    len_nxt,    c_len;
  logic [LW-1:0]       body_r,   body_nxt,   c_body;
  logic [BW-1:0]       bytes_r,  bytes_nxt,  c_bytes;
  logic                skip_r,   skip_nxt,   c_skip;

  logic [7:0]    b;
  logic          is_lf, is_cr, is_sp, is_colon, is_ws, is_digit;
  logic          over, top, hv, line_empty, hd, fin;
  logic [LW-1:0] body_inc;
  logic [2:0]    mf_end, mf_char;
  logic [LW+3:0] prod;
  logic [LW-1:0] nval_fed;
  logic [1:0]    mcode;

  // per-request clear applied before the byte
  always_comb begin
    if (item.new_request) begin
      c_phase  = hrp_pkg::PH_METHOD;
      c_tok    = '0;
      c_mflags = 3'b111;
      c_name   = '0;
      c_nmatch = 1'b1;
      c_val    = '0;
      c_nstage = hrp_pkg::NS_SKIP;
      c_neg    = 1'b0;
      c_seen   = 1'b0;
      c_nval   = '0;
      c_len    = '0;
      c_body   = '0;
      c_bytes  = '0;
      c_skip   = 1'b0;
    end else begin
      c_phase  = phase_r;
      c_tok    = tok_r;
      c_mflags = mflags_r;
      c_name   = name_r;
      c_nmatch = nmatch_r;
      c_val    = val_r;
      c_nstage = nstage_r;
      c_neg    = neg_r;
      c_seen   = seen_r;
      c_nval   = nval_r;
      c_len    = len_r;
      c_body   = body_r;
      c_bytes  = bytes_r;
      c_skip   = skip_r;
    end
  end

  assign b        = item.rx_byte;
  assign is_lf    = (b == hrp_pkg::CHR_LF);
  assign is_cr    = (b == hrp_pkg::CHR_CR);
  assign is_sp    = (b == hrp_pkg::CHR_SP);
  assign is_colon = (b == hrp_pkg::CHR_COLON);
  assign is_ws    = is_sp || (b == hrp_pkg::CHR_TAB) || (b == hrp_pkg::CHR_VT) ||
                    (b == hrp_pkg::CHR_FF);
  assign is_digit = (b >= hrp_pkg::CHR_0) && (b <= hrp_pkg::CHR_9);

  assign over = (c_phase < hrp_pkg::PH_DONE) && (c_bytes >= max_bytes);
  assign p    = over ? hrp_pkg::PH_ABORT : c_phase;

  assign top        = (p <= hrp_pkg::PH_REST);
  assign hv         = (p == hrp_pkg::PH_NAME) || (p == hrp_pkg::PH_VALUE);
  assign line_empty = (c_name == '0) && (c_val == '0);
  assign body_inc   = (c_body < hrp_pkg::LEN_CAP) ? c_body + LW'(1) : c_body;
  assign hd         = hv && is_lf && line_empty;
  assign fin        = (hd && (c_len == '0)) ||
                      ((p == hrp_pkg::PH_BODY) && (body_inc >= c_len));

  // method candidates: GET, HEAD, POST in bits 0..2
  always_comb begin
    mf_end = c_mflags;
    if (c_tok < TOK_W'(3)) mf_end[0] = 1'b0;
    if (c_tok < TOK_W'(4)) mf_end[2:1] = 2'b00;
    mf_char = c_mflags;
    if (c_tok < TOK_W'(3) && b != hrp_pkg::get_char(c_tok[1:0])) mf_char[0] = 1'b0;
    if (c_tok < TOK_W'(4)) begin
      if (b != hrp_pkg::head_char(c_tok[1:0])) mf_char[1] = 1'b0;
      if (b != hrp_pkg::post_char(c_tok[1:0])) mf_char[2] = 1'b0;
    end
  end

  assign prod     = (LW+4)'({c_nval, 3'b000}) + (LW+4)'({c_nval, 1'b0}) +
                    (LW+4)'(b[3:0]);
  assign nval_fed = (prod > (LW+4)'(hrp_pkg::LEN_CAP)) ? hrp_pkg::LEN_CAP : prod[LW-1:0];

  // next state
  always_comb begin
    phase_nxt  = p;
    tok_nxt    = c_tok;
    mflags_nxt = c_mflags;
    name_nxt   = c_name;
    nmatch_nxt = c_nmatch;
    val_nxt    = c_val;
    nstage_nxt = c_nstage;
    neg_nxt    = c_neg;
    seen_nxt   = c_seen;
    nval_nxt   = c_nval;
    len_nxt    = c_len;
    body_nxt   = c_body;
    bytes_nxt  = (c_phase < hrp_pkg::PH_DONE && !over) ? c_bytes + BW'(1) : c_bytes;
    skip_nxt   = c_skip;

    if (top) begin
      if (is_lf) begin
        if (p == hrp_pkg::PH_METHOD) mflags_nxt = mf_end;
        phase_nxt  = hrp_pkg::PH_NAME;
        tok_nxt    = '0;
        name_nxt   = '0;
        nmatch_nxt = 1'b1;
        val_nxt    = '0;
        nstage_nxt = hrp_pkg::NS_SKIP;
        neg_nxt    = 1'b0;
        seen_nxt   = 1'b0;
        nval_nxt   = '0;
        skip_nxt   = 1'b0;
      end else if (is_sp) begin
        if (p == hrp_pkg::PH_METHOD) begin
          mflags_nxt = mf_end;
          phase_nxt  = hrp_pkg::PH_RESOURCE;
        end else if (p == hrp_pkg::PH_RESOURCE) begin
          phase_nxt = hrp_pkg::PH_REST;
        end
        tok_nxt = '0;
      end else if (!is_cr) begin
        if (p == hrp_pkg::PH_METHOD) mflags_nxt = mf_char;
        if (!(&c_tok)) tok_nxt = c_tok + TOK_W'(1);
      end
    end else if (hv) begin
      skip_nxt = 1'b0;
      if (is_lf) begin
        if (line_empty) begin
          if (c_len != '0) begin
            phase_nxt = hrp_pkg::PH_BODY;
            body_nxt  = '0;
          end
        end else begin
          if (c_nmatch && c_name == NAME_W'(hrp_pkg::CL_WORD_LEN) && c_seen)
            len_nxt = c_neg ? '0 : c_nval;
          name_nxt   = '0;
          nmatch_nxt = 1'b1;
          val_nxt    = '0;
          nstage_nxt = hrp_pkg::NS_SKIP;
          neg_nxt    = 1'b0;
          seen_nxt   = 1'b0;
          nval_nxt   = '0;
          phase_nxt  = hrp_pkg::PH_NAME;
        end
      end else if (is_colon) begin
        phase_nxt = hrp_pkg::PH_VALUE;
        skip_nxt  = 1'b1;
      end else if (is_cr || (is_sp && c_skip)) begin
        phase_nxt = p;
      end else if (p == hrp_pkg::PH_NAME) begin
        if (c_name < NAME_W'(NAME_LEN - 1)) begin
          if (c_name >= NAME_W'(hrp_pkg::CL_WORD_LEN) ||
              b != hrp_pkg::cl_char(c_name[3:0]))
            nmatch_nxt = 1'b0;
          name_nxt = c_name + NAME_W'(1);
        end
      end else begin
        if (c_val < VAL_W'(VALUE_LEN - 1)) begin
          val_nxt = c_val + VAL_W'(1);
          if (c_nstage == hrp_pkg::NS_SKIP && is_ws) begin
            nstage_nxt = hrp_pkg::NS_SKIP;
          end else if (c_nstage == hrp_pkg::NS_SKIP && b == hrp_pkg::CHR_PLUS) begin
            nstage_nxt = hrp_pkg::NS_SIGN;
          end else if (c_nstage == hrp_pkg::NS_SKIP && b == hrp_pkg::CHR_MINUS) begin
            nstage_nxt = hrp_pkg::NS_SIGN;
            neg_nxt    = 1'b1;
          end else if (c_nstage != hrp_pkg::NS_STOP && is_digit) begin
            nval_nxt   = nval_fed;
            seen_nxt   = 1'b1;
            nstage_nxt = hrp_pkg::NS_DIGITS;
          end else begin
            nstage_nxt = hrp_pkg::NS_STOP;
          end
        end
      end
    end else if (p == hrp_pkg::PH_BODY) begin
      body_nxt = body_inc;
    end

    if (fin) phase_nxt = hrp_pkg::PH_DONE;
  end

  always_comb begin
    if (phase_nxt == hrp_pkg::PH_METHOD) mcode = hrp_pkg::MTH_NONE;
    else if (mflags_nxt[0])              mcode = hrp_pkg::MTH_GET;
    else if (mflags_nxt[1])              mcode = hrp_pkg::MTH_HEAD;
    else if (mflags_nxt[2])              mcode = hrp_pkg::MTH_POST;
    else                                 mcode = hrp_pkg::MTH_NONE;
  end

  // result
  always_comb begin
    result                = '0;
    result.data_byte      = b;
    result.byte_class     = hrp_pkg::CLS_DROP;
    result.stored         = 1'b0;
    result.headers_done   = hd;
    result.request_done   = fin;
    result.method_code    = mcode;
    result.content_length = len_nxt;
    if (over)                                    result.error_code = hrp_pkg::ERR_SIZE;
    else if (fin && mcode == hrp_pkg::MTH_NONE)  result.error_code = hrp_pkg::ERR_METHOD;
    else                                         result.error_code = hrp_pkg::ERR_NONE;

    if (top) begin
      if (!is_lf && !is_sp && !is_cr) begin
        case (p)
          hrp_pkg::PH_METHOD: begin
            result.byte_class = hrp_pkg::CLS_METHOD;
            result.stored     = (c_tok < TOK_W'(METHOD_LEN - 1));
          end
          hrp_pkg::PH_RESOURCE: begin
            result.byte_class = hrp_pkg::CLS_RESOURCE;
            result.stored     = (c_tok < TOK_W'(RESOURCE_LEN - 1));
          end
          default: result.byte_class = hrp_pkg::CLS_REST;
        endcase
      end
    end else if (hv) begin
      if (!is_lf && !is_colon && !is_cr && !(is_sp && c_skip)) begin
        if (p == hrp_pkg::PH_NAME) begin
          result.byte_class = hrp_pkg::CLS_NAME;
          result.stored     = (c_name < NAME_W'(NAME_LEN - 1));
        end else begin
          result.byte_class = hrp_pkg::CLS_VALUE;
          result.stored     = (c_val < VAL_W'(VALUE_LEN - 1));
        end
      end
    end else if (p == hrp_pkg::PH_BODY) begin
      result.byte_class = hrp_pkg::CLS_BODY;
      result.stored     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= hrp_pkg::PH_METHOD;
      tok_r    <= '0;
      mflags_r <= 3'b111;
      name_r   <= '0;
      nmatch_r <= 1'b1;
      val_r    <= '0;
      nstage_r <= hrp_pkg::NS_SKIP;
      neg_r    <= 1'b0;
      seen_r   <= 1'b0;
      nval_r   <= '0;
      len_r    <= '0;
      body_r   <= '0;
      bytes_r  <= '0;
      skip_r   <= 1'b0;
    end else if (en) begin
      phase_r  <= phase_nxt;
      tok_r    <= tok_nxt;
      mflags_r <= mflags_nxt;
      name_r   <= name_nxt;
      nmatch_r <= nmatch_nxt;
      val_r    <= val_nxt;
      nstage_r <= nstage_nxt;
      neg_r    <= neg_nxt;
      seen_r   <= seen_nxt;
      nval_r   <= nval_nxt;
      len_r    <= len_nxt;
      body_r   <= body_nxt;
      bytes_r  <= bytes_nxt;
      skip_r   <= skip_nxt;
    end
  end

endmodule

### sv/hrp_checker.sv
// ----------------------------------------------------------------------------
// hrp_checker
// Port-level checks on the result stream of the request header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hrp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input hrp_pkg::out_item_t out_data
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `ASSERT_IMPL(a_hdr_on_lf, clk, rst_n, out_valid && out_data.headers_done, out_data.data_byte == hrp_pkg::CHR_LF && out_data.byte_class == hrp_pkg::CLS_DROP)
  `ASSERT_IMPL(a_method_err_at_done, clk, rst_n, out_valid && out_data.error_code == hrp_pkg::ERR_METHOD, out_data.request_done)
  `ASSERT_IMPL(a_done_no_overrun, clk, rst_n, out_valid && out_data.request_done, out_data.error_code != hrp_pkg::ERR_SIZE)
  `ASSERT_IMPL(a_stored_class, clk, rst_n, out_valid && out_data.stored, out_data.byte_class != hrp_pkg::CLS_DROP && out_data.byte_class != hrp_pkg::CLS_REST)

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/tb_http_request_header_parser.sv
// ----------------------------------------------------------------------------
// tb_http_request_header_parser
// Self-checking bench for the HTTP request header parser. A short directed
// table (method classes, empty header line, bytes after completion, the zero
// byte) runs first. Then come random requests, mostly well formed with random
// content and some noise, under several size limits and idling mixes. Every
// result transaction is compared field by field with a fixed expected value
// (marked directed rows) or with a byte-level parser model kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_http_request_header_parser;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 40;
  localparam int RESOURCE_LEN  = hrp_pkg::RESOURCE_LEN_DEF;
  localparam int METHOD_LEN    = hrp_pkg::METHOD_LEN_DEF;
  localparam int NAME_LEN      = hrp_pkg::NAME_LEN_DEF;
  localparam int VALUE_LEN     = hrp_pkg::VALUE_LEN_DEF;
  localparam logic [111:0] WORD_CL   = "Content-Length";
  localparam logic [111:0] WORD_GET  = "GET";
  localparam logic [111:0] WORD_HEAD = "HEAD";
  localparam logic [111:0] WORD_POST = "POST";

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    hrp_pkg::in_item_t  item;
    bit                 fixed;
    hrp_pkg::out_item_t want;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  hrp_pkg::in_item_t            in_data = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  hrp_pkg::out_item_t           out_data;
  logic                         cfg_wr_en = 1'b0;
  logic [hrp_pkg::BYTES_W-1:0]  cfg_wr_data = '0;

  idle_mode_t          mode = IDLE_NONE;
  hrp_pkg::out_item_t  byte_results_q[$];
  hrp_pkg::in_item_t   req_q[$];
  dir_row_t            dir_tab[$];
  hrp_pkg::out_item_t  exp_res;
  int                  fails = 0;
  int                  cycles = 0;

  // parser model state
  hrp_pkg::phase_t              ph;
  int                           tok;
  logic [2:0]                   mflags;
  int                           nm_cnt;
  logic                         nm_ok;
  int                           val_cnt;
  hrp_pkg::num_stage_t          num_st;
  logic                         num_neg;
  logic                         num_any;
  logic [hrp_pkg::LEN_W-1:0]    num_val;
  logic [hrp_pkg::LEN_W-1:0]    clen;
  logic [hrp_pkg::LEN_W-1:0]    body_cnt;
  logic [hrp_pkg::BYTES_W-1:0]  req_bytes;
  logic                         skip_sp;
  logic [hrp_pkg::BYTES_W-1:0]  lim_bytes;

  http_request_header_parser uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    case (mode)
      IDLE_RECV: out_stall <= ($urandom_range(0, 99) < 68);
      IDLE_BOTH: out_stall <= ($urandom_range(0, 99) < 19);
      default:   out_stall <= 1'b0;
    endcase
  end

  function automatic logic [7:0] word_char(logic [111:0] w, int len, int i);
    return w[8*(len-1-i) +: 8];
  endfunction

  function automatic void reset_line_state();
    nm_cnt = 0;
    nm_ok = 1'b1;
    val_cnt = 0;
    num_st = hrp_pkg::NS_SKIP;
    num_neg = 1'b0;
    num_any = 1'b0;
    num_val = '0;
    skip_sp = 1'b0;
  endfunction

  function automatic void reset_request_state();
    ph = hrp_pkg::PH_METHOD;
    tok = 0;
    mflags = 3'b111;
    clen = '0;
    body_cnt = '0;
    req_bytes = '0;
    reset_line_state();
  endfunction

  function automatic void finish_method_token();
    if (tok < 3) mflags[0] = 1'b0;
    if (tok < 4) mflags[2:1] = 2'b00;
  endfunction

  function automatic logic [1:0] method_class();
    if (ph == hrp_pkg::PH_METHOD) return hrp_pkg::MTH_NONE;
    if (mflags[0]) return hrp_pkg::MTH_GET;
    if (mflags[1]) return hrp_pkg::MTH_HEAD;
    if (mflags[2]) return hrp_pkg::MTH_POST;
    return hrp_pkg::MTH_NONE;
  endfunction

  // %d-style scan of the stored value characters
  function automatic void feed_number(logic [7:0] b);
    logic   dig;
    longint nv;
    dig = (b >= hrp_pkg::CHR_0) && (b <= hrp_pkg::CHR_9);
    if (num_st == hrp_pkg::NS_SKIP) begin
      if (b == hrp_pkg::CHR_SP || b == hrp_pkg::CHR_TAB || b == hrp_pkg::CHR_VT ||
          b == hrp_pkg::CHR_FF) return;
      if (b == hrp_pkg::CHR_PLUS) begin
        num_st = hrp_pkg::NS_SIGN;
        return;
      end
      if (b == hrp_pkg::CHR_MINUS) begin
        num_neg = 1'b1;
        num_st = hrp_pkg::NS_SIGN;
        return;
      end
    end
    if (num_st != hrp_pkg::NS_STOP && dig) begin
      nv = longint'(num_val) * 10 + longint'(b - hrp_pkg::CHR_0);
      if (nv > longint'(hrp_pkg::LEN_CAP)) nv = longint'(hrp_pkg::LEN_CAP);
      num_val = nv[hrp_pkg::LEN_W-1:0];
      num_any = 1'b1;
      num_st = hrp_pkg::NS_DIGITS;
      return;
    end
    num_st = hrp_pkg::NS_STOP;
  endfunction

  function automatic hrp_pkg::out_item_t parse_byte(hrp_pkg::in_item_t it);
    logic [7:0]         b;
    logic [2:0]         cls;
    logic               st, hd, rd, fin, sk;
    logic [1:0]         err;
    hrp_pkg::out_item_t r;
    b = it.rx_byte;
    cls = hrp_pkg::CLS_DROP;
    st = 1'b0;
    hd = 1'b0;
    rd = 1'b0;
    fin = 1'b0;
    err = hrp_pkg::ERR_NONE;
    if (it.new_request) reset_request_state();
    if (ph != hrp_pkg::PH_DONE && ph != hrp_pkg::PH_ABORT) begin
      if (req_bytes >= lim_bytes) begin
        ph = hrp_pkg::PH_ABORT;
        err = hrp_pkg::ERR_SIZE;
      end else begin
        req_bytes++;
      end
    end
    if (ph == hrp_pkg::PH_METHOD || ph == hrp_pkg::PH_RESOURCE || ph == hrp_pkg::PH_REST) begin
      if (b == hrp_pkg::CHR_LF) begin
        if (ph == hrp_pkg::PH_METHOD) finish_method_token();
        ph = hrp_pkg::PH_NAME;
        tok = 0;
        reset_line_state();
      end else if (b == hrp_pkg::CHR_SP) begin
        if (ph == hrp_pkg::PH_METHOD) begin
          finish_method_token();
          ph = hrp_pkg::PH_RESOURCE;
        end else if (ph == hrp_pkg::PH_RESOURCE) begin
          ph = hrp_pkg::PH_REST;
        end
        tok = 0;
      end else if (b != hrp_pkg::CHR_CR) begin
        if (ph == hrp_pkg::PH_METHOD) begin
          cls = hrp_pkg::CLS_METHOD;
          st = (tok < METHOD_LEN - 1);
          if (tok < 3 && b != word_char(WORD_GET, 3, tok)) mflags[0] = 1'b0;
          if (tok < 4) begin
            if (b != word_char(WORD_HEAD, 4, tok)) mflags[1] = 1'b0;
            if (b != word_char(WORD_POST, 4, tok)) mflags[2] = 1'b0;
          end
        end else if (ph == hrp_pkg::PH_RESOURCE) begin
          cls = hrp_pkg::CLS_RESOURCE;
          st = (tok < RESOURCE_LEN - 1);
        end else begin
          cls = hrp_pkg::CLS_REST;
        end
        if (tok < 'hFFFF) tok++;
      end
    end else if (ph == hrp_pkg::PH_NAME || ph == hrp_pkg::PH_VALUE) begin
      sk = skip_sp;
      skip_sp = 1'b0;
      if (b == hrp_pkg::CHR_LF) begin
        if (nm_cnt + val_cnt == 0) begin
          hd = 1'b1;
          if (clen == 0) begin
            fin = 1'b1;
          end else begin
            ph = hrp_pkg::PH_BODY;
            body_cnt = '0;
          end
        end else begin
          if (nm_ok && nm_cnt == hrp_pkg::CL_WORD_LEN && num_any)
            clen = num_neg ? '0 : num_val;
          reset_line_state();
          ph = hrp_pkg::PH_NAME;
        end
      end else if (b == hrp_pkg::CHR_COLON) begin
        ph = hrp_pkg::PH_VALUE;
        skip_sp = 1'b1;
      end else if (b == hrp_pkg::CHR_CR || (b == hrp_pkg::CHR_SP && sk)) begin
        // dropped
      end else if (ph == hrp_pkg::PH_NAME) begin
        cls = hrp_pkg::CLS_NAME;
        if (nm_cnt < NAME_LEN - 1) begin
          st = 1'b1;
          if (nm_cnt >= hrp_pkg::CL_WORD_LEN ||
              b != word_char(WORD_CL, hrp_pkg::CL_WORD_LEN, nm_cnt))
            nm_ok = 1'b0;
          nm_cnt++;
        end
      end else begin
        cls = hrp_pkg::CLS_VALUE;
        if (val_cnt < VALUE_LEN - 1) begin
          st = 1'b1;
          feed_number(b);
          val_cnt++;
        end
      end
    end else if (ph == hrp_pkg::PH_BODY) begin
      cls = hrp_pkg::CLS_BODY;
      st = 1'b1;
      if (body_cnt < hrp_pkg::LEN_CAP) body_cnt++;
      if (body_cnt >= clen) fin = 1'b1;
    end
    if (fin) begin
      rd = 1'b1;
      ph = hrp_pkg::PH_DONE;
      if (method_class() == hrp_pkg::MTH_NONE) err = hrp_pkg::ERR_METHOD;
    end
    r.data_byte      = b;
    r.byte_class     = cls;
    r.stored         = st;
    r.headers_done   = hd;
    r.request_done   = rd;
    r.method_code    = method_class();
    r.content_length = clen;
    r.error_code     = err;
    return r;
  endfunction

  function automatic hrp_pkg::out_item_t mk_out(logic [7:0] b, logic [2:0] cls, logic st,
                                                logic hd, logic rd, logic [1:0] mth,
                                                logic [hrp_pkg::LEN_W-1:0] cl,
                                                logic [1:0] err);
    hrp_pkg::out_item_t r;
    r.data_byte      = b;
    r.byte_class     = cls;
    r.stored         = st;
    r.headers_done   = hd;
    r.request_done   = rd;
    r.method_code    = mth;
    r.content_length = cl;
    r.error_code     = err;
    return r;
  endfunction

  task automatic row(logic [7:0] b, logic nr);
    dir_row_t d;
    d.item.rx_byte = b;
    d.item.new_request = nr;
    d.fixed = 1'b0;
    d.want = '0;
    dir_tab.push_back(d);
  endtask

  task automatic row_fixed(logic [7:0] b, logic nr, hrp_pkg::out_item_t w);
    dir_row_t d;
    d.item.rx_byte = b;
    d.item.new_request = nr;
    d.fixed = 1'b1;
    d.want = w;
    dir_tab.push_back(d);
  endtask

  task automatic check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (byte_results_q.size() == 0) begin
        $display("%0t: result transaction with nothing expected, expected none, got %p",
                 $time, out_data);
        fails++;
      end else begin
        exp_res = byte_results_q.pop_front();
        check_field("data_byte", 32'(exp_res.data_byte), 32'(out_data.data_byte));
        check_field("byte_class", 32'(exp_res.byte_class), 32'(out_data.byte_class));
        check_field("stored", 32'(exp_res.stored), 32'(out_data.stored));
        check_field("headers_done", 32'(exp_res.headers_done),
                    32'(out_data.headers_done));
        check_field("request_done", 32'(exp_res.request_done),
                    32'(out_data.request_done));
        check_field("method_code", 32'(exp_res.method_code), 32'(out_data.method_code));
        check_field("content_length", 32'(exp_res.content_length),
                    32'(out_data.content_length));
        check_field("error_code", 32'(exp_res.error_code), 32'(out_data.error_code));
      end
    end
  end

  function automatic bit sender_idle();
    case (mode)
      IDLE_SEND: return ($urandom_range(0, 99) < 68);
      IDLE_BOTH: return ($urandom_range(0, 99) < 19);
      default:   return 1'b0;
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(hrp_pkg::in_item_t it, bit fixed, hrp_pkg::out_item_t want);
    hrp_pkg::out_item_t pred;
    while (sender_idle()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = parse_byte(it);
    byte_results_q.push_back(fixed ? want : pred);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (byte_results_q.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [hrp_pkg::BYTES_W-1:0] v);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    lim_bytes = v;
  endtask

  task automatic add_byte(logic [7:0] b);
    hrp_pkg::in_item_t it;
    it.rx_byte = b;
    it.new_request = 1'b0;
    req_q.push_back(it);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic gen_request();
    int                n;
    int                digits;
    bit                is_len;
    logic [7:0]        c;
    hrp_pkg::in_item_t it;
    req_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      // noise with stray request starts
      n = $urandom_range(1, 24);
      repeat (n) begin
        it.rx_byte = 8'($urandom_range(0, 255));
        it.new_request = ($urandom_range(0, 7) == 0);
        req_q.push_back(it);
      end
      return;
    end
    case ($urandom_range(0, 7))
      0: add_text("GET");
      1: add_text("HEAD");
      2: add_text("POST");
      3: add_text("GETS");
      4: add_text("POSTER");
      5: repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(8'h41, 8'h5a)));
      6: add_text("GE");
      default: add_text("HEA");
    endcase
    if ($urandom_range(0, 7) == 0) begin
      add_byte(hrp_pkg::CHR_LF);
    end else begin
      add_byte(hrp_pkg::CHR_SP);
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(95, 135) : $urandom_range(0, 8);
      repeat (n) begin
        do c = 8'($urandom_range(0, 255));
        while (c == hrp_pkg::CHR_LF || c == hrp_pkg::CHR_SP);
        add_byte(c);
      end
      if ($urandom_range(0, 2) == 0) begin
        add_byte(hrp_pkg::CHR_SP);
        add_text("HTTP/1.1");
      end
      if ($urandom_range(0, 3) != 0) add_byte(hrp_pkg::CHR_CR);
      add_byte(hrp_pkg::CHR_LF);
    end
    repeat ($urandom_range(0, 2)) begin
      is_len = 1'b0;
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          add_text("Content-Length");
          is_len = 1'b1;
        end
        3: add_text("Content-Lengthy");
        4: add_text("content-length");
        default: repeat ($urandom_range(1, 24)) add_byte(8'($urandom_range(8'h41, 8'h7a)));
      endcase
      if ($urandom_range(0, 9) != 0) begin
        add_byte(hrp_pkg::CHR_COLON);
        repeat ($urandom_range(0, 2)) add_byte(hrp_pkg::CHR_SP);
        if (is_len && $urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 4) == 0) add_byte(hrp_pkg::CHR_TAB);
          case ($urandom_range(0, 5))
            0: add_byte(hrp_pkg::CHR_PLUS);
            1: add_byte(hrp_pkg::CHR_MINUS);
            default: ;
          endcase
          digits = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : 1;
          if (digits == 1) add_byte(hrp_pkg::CHR_0 + 8'($urandom_range(0, 4)));
          else repeat (digits) add_byte(hrp_pkg::CHR_0 + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 5) == 0) add_text("x1");
        end else begin
          repeat ($urandom_range(0, 12)) add_byte(8'($urandom_range(8'h21, 8'h7e)));
        end
      end
      if ($urandom_range(0, 3) != 0) add_byte(hrp_pkg::CHR_CR);
      add_byte(hrp_pkg::CHR_LF);
    end
    case ($urandom_range(0, 7))
      0: add_text(":\n");
      1: add_byte(hrp_pkg::CHR_LF);
      default: add_text("\r\n");
    endcase
    repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, req_q.size());
      while (req_q.size() > n) void'(req_q.pop_back());
    end
    req_q[0].new_request = 1'b1;
  endtask

  initial begin
    logic [hrp_pkg::BYTES_W-1:0] cfg_vals[5];
    idle_mode_t                  modes[5];
    int                          sent;
    bit                          paused;

    lim_bytes = hrp_pkg::MAX_BYTES_RST;
    reset_request_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // GET, colon-only line ends the headers
    row_fixed("G", 1'b1, mk_out("G", hrp_pkg::CLS_METHOD, 1'b1, 1'b0, 1'b0,
                                hrp_pkg::MTH_NONE, '0, hrp_pkg::ERR_NONE));
    row("E", 1'b0);
    row("T", 1'b0);
    row(hrp_pkg::CHR_SP, 1'b0);
    row("/", 1'b0);
    row(hrp_pkg::CHR_CR, 1'b0);
    row(hrp_pkg::CHR_LF, 1'b0);
    row(hrp_pkg::CHR_COLON, 1'b0);
    row_fixed(hrp_pkg::CHR_LF, 1'b0,
              mk_out(hrp_pkg::CHR_LF, hrp_pkg::CLS_DROP, 1'b0, 1'b1, 1'b1,
                     hrp_pkg::MTH_GET, '0, hrp_pkg::ERR_NONE));
    row_fixed(8'hff, 1'b0, mk_out(8'hff, hrp_pkg::CLS_DROP, 1'b0, 1'b0, 1'b0,
                                  hrp_pkg::MTH_GET, '0, hrp_pkg::ERR_NONE));
    // method ended by LF, unsupported
    row("X", 1'b1);
    row(hrp_pkg::CHR_LF, 1'b0);
    row_fixed(hrp_pkg::CHR_LF, 1'b0,
              mk_out(hrp_pkg::CHR_LF, hrp_pkg::CLS_DROP, 1'b0, 1'b1, 1'b1,
                     hrp_pkg::MTH_NONE, '0, hrp_pkg::ERR_METHOD));
    // HEAD with a zero byte resource and a short header
    row("H", 1'b1);
    row("E", 1'b0);
    row("A", 1'b0);
    row("D", 1'b0);
    row(hrp_pkg::CHR_SP, 1'b0);
    row(8'h00, 1'b0);
    row(hrp_pkg::CHR_LF, 1'b0);
    row("A", 1'b0);
    row(hrp_pkg::CHR_COLON, 1'b0);
    row(hrp_pkg::CHR_SP, 1'b0);
    row(hrp_pkg::CHR_MINUS, 1'b0);
    row("7", 1'b0);
    row(hrp_pkg::CHR_LF, 1'b0);
    row_fixed(hrp_pkg::CHR_LF, 1'b0,
              mk_out(hrp_pkg::CHR_LF, hrp_pkg::CLS_DROP, 1'b0, 1'b1, 1'b1,
                     hrp_pkg::MTH_HEAD, '0, hrp_pkg::ERR_NONE));

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].want);

    cfg_vals[0] = 18'h3ffff;
    cfg_vals[1] = 18'd1;
    cfg_vals[2] = 18'd40;
    cfg_vals[3] = hrp_pkg::MAX_BYTES_RST;
    cfg_vals[4] = 18'($urandom_range(2, 300));
    modes[0] = IDLE_NONE;
    modes[1] = IDLE_SEND;
    modes[2] = IDLE_RECV;
    modes[3] = IDLE_BOTH;
    modes[4] = IDLE_SEND;

    for (int p = 0; p < 5; p++) begin
      cfg_write(cfg_vals[p]);
      mode = modes[p];
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        gen_request();
        foreach (req_q[i]) begin
          send_item(req_q[i], 1'b0, '0);
          sent++;
        end
        // hold off until the pipeline has fully drained
        if (p == 2 && !paused && sent >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fails == 0 && byte_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
